/* rtl/psl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types and fixed constants of the pixel lightness pipeline.
// ----------------------------------------------------------------------------
package psl_pkg;

    localparam int PIX_W       = 8;
    localparam int NUM_W       = 11;
    localparam int LIGHT_W     = 17;
    localparam int LIGHT_FRAC  = 16;
    localparam logic [LIGHT_W-1:0] LIGHT_ONE   = 17'd65536;
    localparam logic [LIGHT_W-1:0] LIGHT_RESET = 17'd45875;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic [NUM_W-1:0] num_h;
        logic [PIX_W-1:0] den_h;
        logic [NUM_W-1:0] num_s;
        logic [PIX_W-1:0] den_s;
    } t_div_req;

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } t_seg;

endpackage

/* rtl/psl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_front
// Finds max, min and spread of a pixel and forms the hue and saturation
// dividends and divisors.
// ----------------------------------------------------------------------------
module psl_front
    import psl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_pixel   i_pixel,
    output logic     o_valid,
    output t_div_req o_req
);

    logic [PIX_W-1:0] r, g, b, mx, mn, diff;
    logic [NUM_W-1:0] d11, n_num;
    logic             r_valid;
    t_div_req         r_req;

    assign r = i_pixel.red;
    assign g = i_pixel.green;
    assign b = i_pixel.blue;

    always_comb begin
        if (r > g) begin
            mx = r;
            mn = g;
        end else begin
            mx = g;
            mn = r;
        end
        if (b > mx) begin
            mx = b;
        end else if (b < mn) begin
            mn = b;
        end
        diff = mx - mn;
        d11  = {3'b000, diff};
        // Hue numerator in sixths of a turn; red wins ties, then green.
        if (mx == r) begin
            if (g < b) begin
                n_num = (d11 << 2) + (d11 << 1) - {3'b000, b - g};
            end else begin
                n_num = {3'b000, g - b};
            end
        end else if (mx == g) begin
            n_num = (d11 << 1) + {3'b000, b} - {3'b000, r};
        end else begin
            n_num = (d11 << 2) + {3'b000, r} - {3'b000, g};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req.num_h <= n_num;
            r_req.den_h <= diff;
            r_req.num_s <= d11;
            r_req.den_s <= mx;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

/* rtl/psl_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_div
// Pipelined restoring divider, one quotient bit per stage. Computes
// floor(num * 2^FRAC_BITS / den) for num < 8*den; zero when den is zero.
// ----------------------------------------------------------------------------
module psl_div
    import psl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [NUM_W-1:0]       i_num,
    input  logic [PIX_W-1:0]       i_den,
    output logic                   o_valid,
    output logic [FRAC_BITS+2:0]   o_quot
);

    localparam int QW = FRAC_BITS + 3;

    logic [PIX_W-1:0] r_rem   [QW];
    logic [PIX_W-1:0] r_den   [QW];
    logic [QW-1:0]    r_dbits [QW];
    logic [QW-1:0]    r_q     [QW];
    logic [QW-1:0]    r_zero;
    logic [QW-1:0]    r_vld;

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [PIX_W-1:0] a_rem, a_den;
            logic [QW-1:0]    a_dbits, a_q;
            logic             a_zero, a_vld, ge;
            logic [PIX_W:0]   t, n_rem;

            if (k == 0) begin : g_first
                // The quotient is below 8*2^F, so the top eight dividend bits
                // already form a remainder smaller than the divisor.
                assign a_rem   = i_num[NUM_W-1:3];
                assign a_dbits = {i_num[2:0], {FRAC_BITS{1'b0}}};
                assign a_q     = '0;
                assign a_den   = i_den;
                assign a_zero  = (i_den == '0);
                assign a_vld   = i_valid;
            end else begin : g_next
                assign a_rem   = r_rem[k-1];
                assign a_dbits = r_dbits[k-1];
                assign a_q     = r_q[k-1];
                assign a_den   = r_den[k-1];
                assign a_zero  = r_zero[k-1];
                assign a_vld   = r_vld[k-1];
            end

            assign t     = {a_rem, a_dbits[QW-1]};
            assign ge    = (t >= {1'b0, a_den});
            assign n_rem = ge ? (t - {1'b0, a_den}) : t;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= a_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]   <= n_rem[PIX_W-1:0];
                    r_dbits[k] <= {a_dbits[QW-2:0], 1'b0};
                    r_q[k]     <= {a_q[QW-2:0], ge};
                    r_den[k]   <= a_den;
                    r_zero[k]  <= a_zero;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[QW-1];
    assign o_quot  = r_zero[QW-1] ? '0 : r_q[QW-1];

endmodule

/* rtl/psl_hsl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_hsl
// Rebuilds RGB from hue and saturation at the target lightness, five stages.
// ----------------------------------------------------------------------------
module psl_hsl
    import psl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [FRAC_BITS+2:0] i_h6,
    input  logic [FRAC_BITS:0]   i_s,
    input  logic [LIGHT_W-1:0]   i_lightness,
    output logic                 o_valid,
    output t_pixel               o_pixel
);

    localparam int F  = FRAC_BITS;
    localparam int VW = F + 1;
    localparam int PW = F + 3;
    localparam int MW = 2 * F + 2;
    localparam int LW = LIGHT_W + F;
    localparam logic [PW-1:0] P_ONE   = PW'(1) << F;
    localparam logic [PW-1:0] P_THREE = PW'(3) << F;
    localparam logic [PW-1:0] P_FOUR  = PW'(4) << F;
    localparam logic [PW:0]   P_SIX   = (PW + 1)'(6) << F;
    localparam logic [VW-1:0] V_HALF  = VW'(1) << (F - 1);

    // Stage A: lightness, L*S product and channel phases.
    logic [LIGHT_W-1:0] lreg;
    logic [LW-1:0]      lwide;
    logic [VW-1:0]      l_val;
    logic               r_a_vld;
    logic [VW-1:0]      r_l, r_s;
    logic [MW-1:0]      r_ls;
    logic [PW-1:0]      r_p [3];

    assign lreg  = (i_lightness > LIGHT_ONE) ? LIGHT_ONE : i_lightness;
    assign lwide = {lreg, {F{1'b0}}};
    assign l_val = lwide[F+LIGHT_FRAC:LIGHT_FRAC];

    // Stage B: T1, T2 and per-channel segment and weight.
    logic [VW-1:0] ls;
    logic [VW:0]   t2_w, t1_w;
    logic          r_b_vld;
    logic [VW-1:0] r_t1, r_t2, r_span;
    t_seg          r_seg_b [3];
    logic [VW-1:0] r_w [3];

    assign ls   = r_ls[2*F:F];
    assign t2_w = (r_l <= V_HALF) ? ({1'b0, r_l} + {1'b0, ls})
                                  : ({1'b0, r_l} + {1'b0, r_s} - {1'b0, ls});
    assign t1_w = {r_l, 1'b0} - t2_w;

    // Stage C: interpolation products.
    logic          r_c_vld;
    logic [VW-1:0] r_t1c, r_t2c;
    t_seg          r_seg_c [3];
    logic [MW-1:0] r_prod [3];

    // Stage D: channel value as a fraction.
    logic          r_d_vld;
    logic [VW-1:0] r_x [3];

    // Stage E: scale to 8 bits.
    logic          r_e_vld;
    logic [PIX_W-1:0] r_chan [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l    <= l_val;
            r_s    <= i_s;
            r_ls   <= MW'(l_val) * MW'(i_s);
            r_t1   <= t1_w[VW-1:0];
            r_t2   <= t2_w[VW-1:0];
            r_span <= t2_w[VW-1:0] - t1_w[VW-1:0];
            r_t1c  <= r_t1;
            r_t2c  <= r_t2;
        end
    end

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_chan
            // Phase offset in sixths of a turn: red 2, green 0, blue 4.
            localparam int KMUL = (c == 0) ? 2 : (c == 1) ? 0 : 4;
            localparam logic [PW:0] KOFF = (PW + 1)'(KMUL) << F;
            logic [PW:0]   psum;
            logic [PW-1:0] n_p;
            t_seg          n_seg;
            logic [VW-1:0] n_w;
            logic [VW:0]   n_x;
            logic [F+8:0]  xmul;
            logic [8:0]    v9;

            assign psum = {1'b0, i_h6} + KOFF;
            assign n_p  = (psum >= P_SIX) ? PW'(psum - P_SIX) : psum[PW-1:0];

            always_comb begin
                if (r_p[c] < P_ONE) begin
                    n_seg = SEG_RISE;
                    n_w   = r_p[c][VW-1:0];
                end else if (r_p[c] < P_THREE) begin
                    n_seg = SEG_HIGH;
                    n_w   = '0;
                end else if (r_p[c] < P_FOUR) begin
                    n_seg = SEG_FALL;
                    n_w   = VW'(P_FOUR - r_p[c]);
                end else begin
                    n_seg = SEG_LOW;
                    n_w   = '0;
                end
            end

            always_comb begin
                case (r_seg_c[c])
                    SEG_RISE, SEG_FALL: n_x = {1'b0, r_t1c} + {1'b0, r_prod[c][2*F:F]};
                    SEG_HIGH:           n_x = {1'b0, r_t2c};
                    SEG_LOW:            n_x = {1'b0, r_t1c};
                    default:            n_x = {1'b0, r_t1c};
                endcase
            end

            // 255*x as 256*x - x.
            assign xmul = {r_x[c], 8'd0} - (F + 9)'(r_x[c]);
            assign v9   = xmul[F+8:F];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_p[c]     <= n_p;
                    r_seg_b[c] <= n_seg;
                    r_w[c]     <= n_w;
                    r_seg_c[c] <= r_seg_b[c];
                    r_prod[c]  <= MW'(r_span) * MW'(r_w[c]);
                    r_x[c]     <= n_x[VW-1:0];
                    r_chan[c]  <= v9[8] ? 8'hFF : v9[7:0];
                end
            end
        end
    endgenerate

    assign o_valid       = r_e_vld;
    assign o_pixel.red   = r_chan[0];
    assign o_pixel.green = r_chan[1];
    assign o_pixel.blue  = r_chan[2];

endmodule

/* rtl/pixel_set_lightness.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_set_lightness
// Replaces the lightness of an RGB pixel stream, keeping hue and saturation.
// ----------------------------------------------------------------------------
// Pipeline: input register, front end, hue and saturation dividers with one
// quotient bit per stage, then the HSL rebuild stages.
// Throughput: one pixel per cycle; a stalled output holds the whole pipeline.
// Reset: synchronous active low; clears all valid bits and loads lightness 0.7.
// ----------------------------------------------------------------------------
module pixel_set_lightness
    import psl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wen,
    input  logic [LIGHT_W-1:0] i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [23:0]        s_axis_tdata,  // red_in, green_in, blue_in
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [23:0]        m_axis_tdata   // red_out, green_out, blue_out
);

    logic               en;
    logic [LIGHT_W-1:0] r_lightness;
    logic               r_in_vld;
    t_pixel             r_in_pix;
    logic               front_vld;
    t_div_req           front_req;
    logic               div_h_vld, div_s_vld;
    logic [FRAC_BITS+2:0] quot_h, quot_s;
    t_pixel             out_pix;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lightness <= LIGHT_RESET;
        end else if (i_cfg_wen) begin
            r_lightness <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_pix <= s_axis_tdata;
        end
    end

    psl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_vld),
        .i_pixel (r_in_pix),
        .o_valid (front_vld),
        .o_req   (front_req)
    );

    psl_div #(.FRAC_BITS(FRAC_BITS)) u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_vld),
        .i_num   (front_req.num_h),
        .i_den   (front_req.den_h),
        .o_valid (div_h_vld),
        .o_quot  (quot_h)
    );

    psl_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_vld),
        .i_num   (front_req.num_s),
        .i_den   (front_req.den_s),
        .o_valid (div_s_vld),
        .o_quot  (quot_s)
    );

    psl_hsl #(.FRAC_BITS(FRAC_BITS)) u_hsl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (div_h_vld),
        .i_h6        (quot_h),
        .i_s         (quot_s[FRAC_BITS:0]),
        .i_lightness (r_lightness),
        .o_valid     (m_axis_tvalid),
        .o_pixel     (out_pix)
    );

    assign m_axis_tdata = out_pix;

    // Both dividers must stay in lockstep.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_h_vld == div_s_vld)
        else $error("hue and saturation dividers out of step");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !div_h_vld && !front_vld)
        else $error("valid survived reset");

    // A pixel in the divider while the output stalls must not advance.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready && div_h_vld |=> div_h_vld && m_axis_tvalid)
        else $error("pipeline moved during stall");

endmodule
